// ===== hw/rtl/rcsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_pkg
// Types and constants shared by the stick and switch conditioner.
// ----------------------------------------------------------------------------
package rcsc_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int NUM_STICKS   = 4;
    localparam int NUM_SWITCHES = 4;
    localparam int NSTAGE       = 6;

    localparam int PULSE_W = 12;
    localparam int STICK_W = 18;
    localparam int LEVEL_W = 16;
    localparam int SEL_W   = 4;

    typedef logic [PULSE_W-1:0]        t_pulse;
    typedef logic signed [STICK_W-1:0] t_stick;
    typedef logic signed [LEVEL_W-1:0] t_level;

    // stick arithmetic
    localparam logic [PULSE_W-1:0] STICK_CENTER = 12'd1500;
    localparam logic [20:0]        DZ_SCALE     = 21'd500;
    localparam logic [40:0]        ROUND_BIAS   = 41'd1024000;
    localparam int                 DIV_SHIFT    = 14;
    localparam logic [23:0]        Q_CLAMP      = 24'd16384125;
    localparam logic [STICK_W-1:0] STICK_MAX_POS = 18'd131071;
    localparam logic [STICK_W-1:0] STICK_MAX_NEG = 18'd131072;

    // floor(x / 125) as (x * RECIP_125) >> RECIP_SHIFT plus one correction step
    localparam logic [24:0] RECIP_125   = 25'd17179869;
    localparam int          RECIP_SHIFT = 31;
    localparam logic [23:0] DIV_125     = 24'd125;

    // switch arithmetic
    localparam logic [20:0]        SW_ROUND     = 21'd62;
    localparam logic [LEVEL_W-1:0] LEVEL_BIAS   = 16'd4096;
    localparam t_level             SWITCH_LIMIT = 16'sd4506;

    localparam int SW_FSM = 0;
    localparam int SW_CMD = 1;
    localparam int SW_RBT = 2;
    localparam int SW_KIL = 3;

    typedef enum logic [2:0] {
        CFG_DEADZONE_LEVEL     = 3'd0,
        CFG_DEADZONE_GAIN      = 3'd1,
        CFG_SWITCH_ON_LEVEL    = 3'd2,
        CFG_CENTERED_THRESHOLD = 3'd3,
        CFG_FSM_CHANNEL_SEL    = 3'd4,
        CFG_COMMAND_CHANNEL_SEL = 3'd5,
        CFG_REBOOT_CHANNEL_SEL = 3'd6,
        CFG_KILL_CHANNEL_SEL   = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [11:0]        deadzone_level;
        logic [15:0]        deadzone_gain;
        logic signed [14:0] switch_on_level;
        logic [13:0]        centered_threshold;
        logic [SEL_W-1:0]   fsm_channel_sel;
        logic [SEL_W-1:0]   command_channel_sel;
        logic [SEL_W-1:0]   reboot_channel_sel;
        logic [SEL_W-1:0]   kill_channel_sel;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        deadzone_level:      12'd410,
        deadzone_gain:       16'd4551,
        switch_on_level:     15'sd2048,
        centered_threshold:  14'd410,
        fsm_channel_sel:     4'd5,
        command_channel_sel: 4'd6,
        reboot_channel_sel:  4'd7,
        kill_channel_sel:    4'd8
    };

    typedef struct packed {
        logic [NSTAGE:1] load;
        logic [NSTAGE:1] valid;
    } t_pipe_ctl;

    typedef struct packed {
        logic fsm_on;
        logic fsm_entered;
        logic command_on;
        logic reboot_entered;
        logic kill_on;
        logic invalid;
    } t_sw_flags;

    typedef struct packed {
        t_stick stick;
        logic   centered;
    } t_lane_out;

endpackage
`default_nettype wire

// ===== hw/rtl/rcsc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_in_if
// Frame channel: eight pulse widths per transaction.
// ----------------------------------------------------------------------------
interface rcsc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] pulse_0;
    logic [11:0] pulse_1;
    logic [11:0] pulse_2;
    logic [11:0] pulse_3;
    logic [11:0] pulse_4;
    logic [11:0] pulse_5;
    logic [11:0] pulse_6;
    logic [11:0] pulse_7;

    modport source (
        output valid, pulse_0, pulse_1, pulse_2, pulse_3,
               pulse_4, pulse_5, pulse_6, pulse_7,
        input  ready
    );
    modport sink (
        input  valid, pulse_0, pulse_1, pulse_2, pulse_3,
               pulse_4, pulse_5, pulse_6, pulse_7,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/rcsc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_out_if
// Result channel: conditioned sticks and switch flags per transaction.
// ----------------------------------------------------------------------------
interface rcsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] stick_0;
    logic signed [17:0] stick_1;
    logic signed [17:0] stick_2;
    logic signed [17:0] stick_3;
    logic               fsm_on;
    logic               fsm_entered;
    logic               command_on;
    logic               reboot_entered;
    logic               kill_on;
    logic               sticks_centered;
    logic               switch_invalid;

    modport source (
        output valid, stick_0, stick_1, stick_2, stick_3, fsm_on, fsm_entered,
               command_on, reboot_entered, kill_on, sticks_centered, switch_invalid,
        input  ready
    );
    modport sink (
        input  valid, stick_0, stick_1, stick_2, stick_3, fsm_on, fsm_entered,
               command_on, reboot_entered, kill_on, sticks_centered, switch_invalid,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/rc_stick_switch_conditioner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc_stick_switch_conditioner_core
// Conditions one radio frame per transaction: four stick lanes in parallel,
// one switch unit, and a merge stage that forms the result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  i_frame   in   valid / ready        pulse_0 .. pulse_7, 12 bit us
//  o_res     out  valid / ready        stick_0 .. stick_3, switch flags
//  i_cfg_*   in   i_cfg_we, no wait    i_cfg_index 3 bit, i_cfg_data 16 bit
//
//  One frame per cycle sustained while the output is not stalled; six register
//  stages, the last one the output register. The depth is set by the stick lane
//  pipeline (gain multiply, reciprocal divide by 125 and its correction).
//  Reset clears the stage valid bits and edge history and loads the register
//  defaults. A stalled output holds; earlier stages keep closing bubbles and
//  ready falls only when all six stages hold a frame.
// ----------------------------------------------------------------------------
module rc_stick_switch_conditioner_core import rcsc_pkg::*; #(
    parameter int STICK_LANES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcsc_in_if.sink           i_frame,
    rcsc_out_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEADZONE_LEVEL:      r_cfg.deadzone_level      <= i_cfg_data[11:0];
                CFG_DEADZONE_GAIN:       r_cfg.deadzone_gain       <= i_cfg_data;
                CFG_SWITCH_ON_LEVEL:     r_cfg.switch_on_level     <= i_cfg_data[14:0];
                CFG_CENTERED_THRESHOLD:  r_cfg.centered_threshold  <= i_cfg_data[13:0];
                CFG_FSM_CHANNEL_SEL:     r_cfg.fsm_channel_sel     <= i_cfg_data[3:0];
                CFG_COMMAND_CHANNEL_SEL: r_cfg.command_channel_sel <= i_cfg_data[3:0];
                CFG_REBOOT_CHANNEL_SEL:  r_cfg.reboot_channel_sel  <= i_cfg_data[3:0];
                CFG_KILL_CHANNEL_SEL:    r_cfg.kill_channel_sel    <= i_cfg_data[3:0];
            endcase
        end
    end

    // pipeline control: a stage loads when empty or when the next one loads
    logic [NSTAGE:1] r_valid;
    logic [NSTAGE:1] n_valid;
    logic [NSTAGE:1] w_load;
    t_pipe_ctl       w_ctl;

    always_comb begin
        w_load[NSTAGE] = !r_valid[NSTAGE] || o_res.ready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
        n_valid = {r_valid[NSTAGE-1:1], i_frame.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (w_load & n_valid) | (~w_load & r_valid);
        end
    end

    assign w_ctl.load    = w_load;
    assign w_ctl.valid   = r_valid;
    assign i_frame.ready = w_load[1];

    t_pulse w_pulse [NUM_CHANNELS];
    assign w_pulse[0] = i_frame.pulse_0;
    assign w_pulse[1] = i_frame.pulse_1;
    assign w_pulse[2] = i_frame.pulse_2;
    assign w_pulse[3] = i_frame.pulse_3;
    assign w_pulse[4] = i_frame.pulse_4;
    assign w_pulse[5] = i_frame.pulse_5;
    assign w_pulse[6] = i_frame.pulse_6;
    assign w_pulse[7] = i_frame.pulse_7;

    // stick lanes; unused lanes read as zero and count as centered
    t_lane_out w_lane [NUM_STICKS];

    for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
        if (g < STICK_LANES) begin : g_used
            rcsc_stick_lane u_lane (
                .i_clk   (i_clk),
                .i_pulse (w_pulse[g]),
                .i_cfg   (r_cfg),
                .i_ctl   (w_ctl),
                .o_lane  (w_lane[g])
            );
        end else begin : g_unused
            assign w_lane[g] = '{stick: '0, centered: 1'b1};
        end
    end

    t_sw_flags w_flags;

    rcsc_switch u_switch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (w_pulse),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl),
        .o_flags (w_flags)
    );

    // merge stage and output register
    t_stick    r_stick [NUM_STICKS];
    t_sw_flags r_flags;
    logic      r_centered;
    logic      n_centered;

    always_comb begin
        n_centered = 1'b1;
        for (int k = 0; k < NUM_STICKS; k++) begin
            n_centered = n_centered && w_lane[k].centered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[NSTAGE]) begin
            for (int k = 0; k < NUM_STICKS; k++) begin
                r_stick[k] <= w_lane[k].stick;
            end
            r_flags    <= w_flags;
            r_centered <= n_centered;
        end
    end

    assign o_res.valid           = r_valid[NSTAGE];
    assign o_res.stick_0         = r_stick[0];
    assign o_res.stick_1         = r_stick[1];
    assign o_res.stick_2         = r_stick[2];
    assign o_res.stick_3         = r_stick[3];
    assign o_res.fsm_on          = r_flags.fsm_on;
    assign o_res.fsm_entered     = r_flags.fsm_entered;
    assign o_res.command_on      = r_flags.command_on;
    assign o_res.reboot_entered  = r_flags.reboot_entered;
    assign o_res.kill_on         = r_flags.kill_on;
    assign o_res.sticks_centered = r_centered;
    assign o_res.switch_invalid  = r_flags.invalid;

endmodule
`default_nettype wire

// ===== hw/rtl/rcsc_stick_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_stick_lane
// One stick: center, dead zone, gain, divide by 2048000, saturate.
// Five registered stages, advancing on the shared load strobes.
// ----------------------------------------------------------------------------
module rcsc_stick_lane import rcsc_pkg::*; (
    input  logic      i_clk,
    input  t_pulse    i_pulse,
    input  t_cfg      i_cfg,
    input  t_pipe_ctl i_ctl,
    output t_lane_out o_lane
);

    localparam int E_W    = 24;
    localparam int PROD_W = E_W + 16;
    localparam int Q_W    = 24;
    localparam int QF_W   = PROD_W + 1 - DIV_SHIFT;
    localparam int RM_W   = Q_W + 25;

    // stage 1: magnitude past the dead zone
    logic             n_neg;
    logic [11:0]      n_m;
    logic [E_W-1:0]   n_scaled;
    logic [20:0]      n_dzs;
    logic [E_W-1:0]   n_e;
    logic             r_neg1, r_neg2, r_neg3, r_neg4;
    logic [E_W-1:0]   r_e;

    always_comb begin
        n_neg    = i_pulse < STICK_CENTER;
        n_m      = n_neg ? STICK_CENTER - i_pulse : i_pulse - STICK_CENTER;
        n_scaled = {n_m, 12'b0};
        n_dzs    = 21'(i_cfg.deadzone_level) * DZ_SCALE;
        n_e      = (n_scaled > E_W'(n_dzs)) ? n_scaled - E_W'(n_dzs) : '0;
    end

    // stage 2: gain
    logic [PROD_W-1:0] r_prod;

    // stage 3: round, drop the power-of-two part of the divisor, clamp
    logic [PROD_W:0]   n_sum;
    logic [QF_W-1:0]   n_qf;
    logic [Q_W-1:0]    n_q;
    logic [Q_W-1:0]    r_q3;

    always_comb begin
        n_sum = (PROD_W+1)'(r_prod) + ROUND_BIAS;
        n_qf  = n_sum[PROD_W:DIV_SHIFT];
        n_q   = (n_qf > QF_W'(Q_CLAMP)) ? Q_CLAMP : n_qf[Q_W-1:0];
    end

    // stage 4: reciprocal estimate of q / 125
    logic [RM_W-1:0]    n_rm;
    logic [STICK_W-1:0] r_approx;
    logic [Q_W-1:0]     r_q4;

    assign n_rm = RM_W'(r_q3) * RM_W'(RECIP_125);

    // stage 5: correct, saturate, sign
    logic [Q_W-1:0]     n_rem;
    logic [STICK_W-1:0] n_r;
    logic [STICK_W-1:0] n_mag;
    t_lane_out          n_lane;
    t_lane_out          r_lane;

    always_comb begin
        n_rem = r_q4 - (Q_W'(r_approx) * DIV_125);
        n_r   = (n_rem >= DIV_125) ? r_approx + 1'b1 : r_approx;
        if (r_neg4) begin
            n_mag = (n_r > STICK_MAX_NEG) ? STICK_MAX_NEG : n_r;
        end else begin
            n_mag = (n_r > STICK_MAX_POS) ? STICK_MAX_POS : n_r;
        end
        n_lane.stick    = r_neg4 ? -$signed(n_mag) : $signed(n_mag);
        n_lane.centered = n_mag < STICK_W'(i_cfg.centered_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_neg1 <= n_neg;
            r_e    <= n_e;
        end
        if (i_ctl.load[2]) begin
            r_neg2 <= r_neg1;
            r_prod <= PROD_W'(r_e) * PROD_W'(i_cfg.deadzone_gain);
        end
        if (i_ctl.load[3]) begin
            r_neg3 <= r_neg2;
            r_q3   <= n_q;
        end
        if (i_ctl.load[4]) begin
            r_neg4   <= r_neg3;
            r_q4     <= r_q3;
            r_approx <= n_rm[RECIP_SHIFT +: STICK_W];
        end
        if (i_ctl.load[5]) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule
`default_nettype wire

// ===== hw/rtl/rcsc_switch.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_switch
// Four selectable switch channels: level in Q.12, threshold, rising edges,
// range check. Edge history advances as each frame leaves stage 3.
// ----------------------------------------------------------------------------
module rcsc_switch import rcsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pulse    i_pulse [NUM_CHANNELS],
    input  t_cfg      i_cfg,
    input  t_pipe_ctl i_ctl,
    output t_sw_flags o_flags
);

    localparam int Y_W  = 21;
    localparam int A_W  = 15;
    localparam int YM_W = Y_W + 25;

    function automatic t_pulse pulse_at(input t_pulse pulses [NUM_CHANNELS],
                                        input logic [SEL_W-1:0] sel);
        logic [SEL_W-1:0] idx;
        idx = sel - 1'b1;
        if (sel == '0 || sel > SEL_W'(NUM_CHANNELS)) begin
            return '0;
        end
        return pulses[idx[CH_IDX_W-1:0]];
    endfunction

    logic [SEL_W-1:0] w_sel [NUM_SWITCHES];
    assign w_sel[SW_FSM] = i_cfg.fsm_channel_sel;
    assign w_sel[SW_CMD] = i_cfg.command_channel_sel;
    assign w_sel[SW_RBT] = i_cfg.reboot_channel_sel;
    assign w_sel[SW_KIL] = i_cfg.kill_channel_sel;

    logic [Y_W-1:0]  n_y    [NUM_SWITCHES];
    logic [Y_W-1:0]  r_y1   [NUM_SWITCHES];
    logic [Y_W-1:0]  r_y2   [NUM_SWITCHES];
    logic [YM_W-1:0] n_ym   [NUM_SWITCHES];
    logic [A_W-1:0]  r_a2   [NUM_SWITCHES];
    logic [Y_W-1:0]  n_rem  [NUM_SWITCHES];
    t_level          n_lvl  [NUM_SWITCHES];
    t_level          r_lvl3 [NUM_SWITCHES];

    // p*4096+500 over 8 is exact as p*512+62; the rest divides by 125
    always_comb begin
        for (int s = 0; s < NUM_SWITCHES; s++) begin
            n_y[s]   = {pulse_at(i_pulse, w_sel[s]), 9'b0} + SW_ROUND;
            n_ym[s]  = YM_W'(r_y1[s]) * YM_W'(RECIP_125);
            n_rem[s] = r_y2[s] - (Y_W'(r_a2[s]) * Y_W'(DIV_125));
            n_lvl[s] = t_level'((LEVEL_W'(r_a2[s]) + LEVEL_W'(n_rem[s] >= Y_W'(DIV_125)))
                                - LEVEL_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SWITCHES; s++) begin
            if (i_ctl.load[1]) begin
                r_y1[s] <= n_y[s];
            end
            if (i_ctl.load[2]) begin
                r_y2[s] <= r_y1[s];
                r_a2[s] <= n_ym[s][RECIP_SHIFT +: A_W];
            end
            if (i_ctl.load[3]) begin
                r_lvl3[s] <= n_lvl[s];
            end
        end
    end

    // stage 4: flags against the threshold and the previous frame
    t_level    w_th;
    logic      r_primed;
    t_level    r_prev_fsm;
    t_level    r_prev_rbt;
    t_sw_flags n_flags;
    t_sw_flags r_flags4;
    t_sw_flags r_flags5;

    assign w_th = LEVEL_W'(i_cfg.switch_on_level);

    function automatic logic out_of_range(input t_level lvl);
        return (lvl < -SWITCH_LIMIT) || (lvl > SWITCH_LIMIT);
    endfunction

    always_comb begin
        n_flags.fsm_on         = r_lvl3[SW_FSM] > w_th;
        n_flags.command_on     = r_lvl3[SW_CMD] > w_th;
        n_flags.kill_on        = r_lvl3[SW_KIL] > w_th;
        n_flags.fsm_entered    = r_primed && (r_prev_fsm < w_th) && (r_lvl3[SW_FSM] > w_th);
        n_flags.reboot_entered = r_primed && (r_prev_rbt < w_th) && (r_lvl3[SW_RBT] > w_th);
        n_flags.invalid        = out_of_range(r_lvl3[SW_FSM]) ||
                                 out_of_range(r_lvl3[SW_CMD]) ||
                                 out_of_range(r_lvl3[SW_RBT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_prev_fsm <= '0;
            r_prev_rbt <= '0;
        end else if (i_ctl.load[4] && i_ctl.valid[3]) begin
            r_primed   <= 1'b1;
            r_prev_fsm <= r_lvl3[SW_FSM];
            r_prev_rbt <= r_lvl3[SW_RBT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_flags4 <= n_flags;
        end
        if (i_ctl.load[5]) begin
            r_flags5 <= r_flags4;
        end
    end

    assign o_flags = r_flags5;

endmodule
`default_nettype wire

// ===== hw/rtl/rcsc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcsc_checker
// Port-level checks on the conditioner: in-flight depth, output stall
// behavior and the first-frame edge rule.
// ----------------------------------------------------------------------------
module rcsc_checker import rcsc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [17:0] i_stick_0,
    input logic               i_fsm_entered,
    input logic               i_reboot_entered
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [2:0] r_count;
    logic       r_delivered;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // track transactions in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_delivered <= 1'b0;
        end else begin
            r_count <= r_count + 3'(w_in_acc) - 3'(w_out_acc);
            if (w_out_acc) begin
                r_delivered <= 1'b1;
            end
        end
    end

    default disable iff (!i_rst_n);

    a_depth: assert property (@(posedge i_clk) r_count <= 3'(NSTAGE))
        else $error("more frames in flight than pipeline stages");

    a_no_orphan: assert property (@(posedge i_clk) i_out_valid |-> r_count != '0)
        else $error("result shown with no frame in flight");

    a_stall_hold: assert property (@(posedge i_clk)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stick_0))
        else $error("stalled result dropped or changed");

    a_first_edge: assert property (@(posedge i_clk)
        i_out_valid && !r_delivered |-> !i_fsm_entered && !i_reboot_entered)
        else $error("edge reported on first frame");

endmodule

bind rc_stick_switch_conditioner_core rcsc_checker u_rcsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_frame.valid),
    .i_in_ready       (i_frame.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_stick_0        (o_res.stick_0),
    .i_fsm_entered    (o_res.fsm_entered),
    .i_reboot_entered (o_res.reboot_entered)
);
`default_nettype wire
